// File: rtl/encoder_position_ema_filter_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ENCODER_POSITION_EMA_FILTER_TOP_DEFINES_SVH
`define ENCODER_POSITION_EMA_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EPF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epf check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("epf check failed");

`endif

// File: rtl/epf_pkg.sv
`default_nettype none
package epf_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int EST_W       = COUNT_WIDTH + FRAC_BITS;
	localparam int ERR_W       = EST_W + 1;
	localparam int ALPHA_W     = 17;
	localparam int ALPHA_FB    = 16;
	localparam int PROD_W      = ERR_W + ALPHA_W;
	localparam int DB_W        = 16;
	localparam int SNAP_W      = 31;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 31;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FB);

	typedef enum logic [CFG_IDX_W-1:0] {
		IDX_ALPHA_TRK = 3'd0,
		IDX_ALPHA_SLW = 3'd1,
		IDX_DEADBAND  = 3'd2,
		IDX_SNAP_TRK  = 3'd3,
		IDX_SNAP_SLW  = 3'd4,
		IDX_BYPASS    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha_trk;
		logic [ALPHA_W-1:0] alpha_slw;
		logic [DB_W-1:0]    deadband;
		logic [SNAP_W-1:0]  snap_trk;
		logic [SNAP_W-1:0]  snap_slw;
		logic               bypass;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/encoder_position_ema_filter_top.sv
// Encoder position smoothing filter: one signed encoder sample (s_tdata) plus a
// tracking flag (s_tuser) per transfer in, one filtered position per transfer
// out, in order. A new sample is taken every cycle unless the output side stalls;
// each accepted sample moves through the estimate register to the rounding output
// register, which drives m_tdata and holds it while m_tready stays low.
// The path crosses three registers: the input register, the estimate register
// (error, deadband and snap compares, alpha multiply and update are combinational,
// so each sample sees the estimate left by the one before) and the
// rounding output register. The first sample after reset, and every slewing
// sample with bypass_on_slew set, loads the estimate and passes through unchanged.
// cfg_ready is always high and indexes beyond bypass_on_slew are ignored. Write
// registers over the cfg port only while no samples are in flight (unchecked).
`default_nettype none
module encoder_position_ema_filter_top
	import epf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// cfg port: index 0 alpha_tracking .. 5 bypass_on_slew
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	input  wire logic [COUNT_WIDTH-1:0] s_tdata,  // [31:0] encoder_count
	input  wire logic                   s_tuser,  // [0] is_tracking
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [COUNT_WIDTH-1:0] m_tdata   // [31:0] filtered_count
);

	cfg_t             cfg;
	logic             out_ready;
	logic             est_valid;
	logic [EST_W-1:0] est_q;

	epf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	epf_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tready  (s_tready),
		.out_ready (out_ready),
		.est_valid (est_valid),
		.est_q     (est_q)
	);

	epf_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.est_valid (est_valid),
		.est_q     (est_q),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// File: rtl/epf_cfg_regs.sv
`default_nettype none
module epf_cfg_regs
	import epf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output      logic                  cfg_ready,
	output      cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_trk <= ALPHA_ONE;
			cfg_q.alpha_slw <= ALPHA_ONE;
			cfg_q.deadband  <= '0;
			cfg_q.snap_trk  <= '0;
			cfg_q.snap_slw  <= '0;
			cfg_q.bypass    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				IDX_ALPHA_TRK: cfg_q.alpha_trk <= cfg_data[ALPHA_W-1:0];
				IDX_ALPHA_SLW: cfg_q.alpha_slw <= cfg_data[ALPHA_W-1:0];
				IDX_DEADBAND:  cfg_q.deadband  <= cfg_data[DB_W-1:0];
				IDX_SNAP_TRK:  cfg_q.snap_trk  <= cfg_data[SNAP_W-1:0];
				IDX_SNAP_SLW:  cfg_q.snap_slw  <= cfg_data[SNAP_W-1:0];
				IDX_BYPASS:    cfg_q.bypass    <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/epf_update.sv
`default_nettype none
module epf_update
	import epf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   s_tvalid,
	input  wire logic [COUNT_WIDTH-1:0] s_tdata,
	input  wire logic                   s_tuser,
	output      logic                   s_tready,
	input  wire logic                   out_ready,
	output      logic                   est_valid,
	output      logic [EST_W-1:0]       est_q
);

	logic                   v_s1;
	logic [COUNT_WIDTH-1:0] x_s1;
	logic                   trk_s1;
	logic                   loaded_q;

	logic                   rdy_s2;
	logic                   adv_s1;

	logic [EST_W-1:0]       xs;
	logic [ERR_W-1:0]       est_ext;
	logic [ERR_W-1:0]       err;
	logic                   err_neg;
	logic [ERR_W-1:0]       mag;
	logic                   db_hit;
	logic [SNAP_W-1:0]      snap_sel;
	logic                   snap_hit;
	logic [ALPHA_W-1:0]     alpha_sel;
	logic [ALPHA_W-1:0]     alpha_c;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-1:0]      prod_rnd;
	logic [ERR_W-1:0]       step;
	logic [ERR_W-1:0]       moved;
	logic [EST_W-1:0]       est_next;

	// stage 2 is the estimate register itself; it empties into the output stage
	assign rdy_s2   = !est_valid || out_ready;
	assign s_tready = !v_s1 || rdy_s2;
	assign adv_s1   = v_s1 && rdy_s2;

	always_comb begin
		xs      = {x_s1, {FRAC_BITS{1'b0}}};
		est_ext = {est_q[EST_W-1], est_q};
		err     = {xs[EST_W-1], xs} - est_ext;
		err_neg = err[ERR_W-1];
		mag     = err_neg ? (~err + ERR_W'(1)) : err;

		db_hit   = mag < ERR_W'({cfg.deadband, {FRAC_BITS{1'b0}}});
		snap_sel = trk_s1 ? cfg.snap_trk : cfg.snap_slw;
		snap_hit = (snap_sel != '0) && (mag >= ERR_W'({snap_sel, {FRAC_BITS{1'b0}}}));

		// alpha above one behaves as one, so the estimate never overshoots
		alpha_sel = trk_s1 ? cfg.alpha_trk : cfg.alpha_slw;
		alpha_c   = (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;
		prod      = PROD_W'(mag) * PROD_W'(alpha_c);
		prod_rnd  = prod + PROD_W'(1 << (ALPHA_FB - 1));
		step      = prod_rnd[ALPHA_FB +: ERR_W];
		moved     = err_neg ? (est_ext - step) : (est_ext + step);

		priority if (!loaded_q || (cfg.bypass && !trk_s1)) begin
			est_next = xs;
		end else if (db_hit) begin
			est_next = est_q;
		end else if (snap_hit) begin
			est_next = xs;
		end else begin
			est_next = moved[EST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			est_valid <= 1'b0;
			loaded_q  <= 1'b0;
			est_q     <= '0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				est_valid <= v_s1;
			end
			if (adv_s1) begin
				est_q    <= est_next;
				loaded_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1   <= s_tdata;
			trk_s1 <= s_tuser;
		end
	end

endmodule
`default_nettype wire

// File: rtl/epf_round.sv
`default_nettype none
module epf_round
	import epf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   est_valid,
	input  wire logic [EST_W-1:0]       est_q,
	output      logic                   out_ready,
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [COUNT_WIDTH-1:0] m_tdata
);

	logic [ERR_W-1:0] sum;
	logic             ld;

	assign out_ready = !m_tvalid || m_tready;
	assign ld        = est_valid && out_ready;

	// half away from zero: negative values add one less than half, then floor
	assign sum = {est_q[EST_W-1], est_q} + ERR_W'(1 << (FRAC_BITS - 1))
		- ERR_W'(est_q[EST_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= est_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_tdata <= sum[FRAC_BITS +: COUNT_WIDTH];
		end
	end

endmodule
`default_nettype wire

// File: rtl/epf_checker.sv
`default_nettype none
`include "encoder_position_ema_filter_top_defines.svh"
module epf_checker
	import epf_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [COUNT_WIDTH-1:0] m_tdata
);

	// a stalled result holds its value
	`EPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// an empty output register never backs up the input side
	`EPF_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready)

	// with the output side draining, an accepted sample comes out on m_tvalid
	`EPF_ASSERT_NEXT(a_latency, (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready,
		m_tvalid)

	// register writes are never back-pressured
	`EPF_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind encoder_position_ema_filter_top epf_checker u_epf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
`default_nettype wire

// File: verif/encoder_position_ema_filter_top_tb.sv
`default_nettype none
module encoder_position_ema_filter_top_tb;
	import epf_pkg::*;

	localparam bit TRACKING = 1'b1;
	localparam bit SLEWING  = 1'b0;
	// indexes past bypass_on_slew, which the block must ignore
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam int LONG_HOLD    = 200;

	class ema_scoreboard;
		logic [63:0]            estimate;  // signed, FRAC_BITS fraction bits
		bit                     loaded;
		cfg_t                   regs;
		logic [COUNT_WIDTH-1:0] expected_positions[$];
		int                     mismatch_count;

		function new();
			estimate = '0;
			loaded = 1'b0;
			mismatch_count = 0;
			regs.alpha_trk = ALPHA_ONE;
			regs.alpha_slw = ALPHA_ONE;
			regs.deadband = '0;
			regs.snap_trk = '0;
			regs.snap_slw = '0;
			regs.bypass = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			IDX_ALPHA_TRK: regs.alpha_trk = val[ALPHA_W-1:0];
			IDX_ALPHA_SLW: regs.alpha_slw = val[ALPHA_W-1:0];
			IDX_DEADBAND:  regs.deadband = val[DB_W-1:0];
			IDX_SNAP_TRK:  regs.snap_trk = val[SNAP_W-1:0];
			IDX_SNAP_SLW:  regs.snap_slw = val[SNAP_W-1:0];
			IDX_BYPASS:    regs.bypass = val[0];
			default: ;
			endcase
		endfunction

		// advance the estimate by one sample and queue the position it yields
		function void note_sample(logic [COUNT_WIDTH-1:0] cnt, bit trk);
			logic [63:0]        xs;
			logic [63:0]        err;
			logic [63:0]        mag;
			logic [63:0]        lim;
			logic [63:0]        step;
			logic [63:0]        r;
			logic [81:0]        prod;
			logic [ALPHA_W-1:0] alpha;
			xs = {{(64 - EST_W){cnt[COUNT_WIDTH-1]}}, cnt, {FRAC_BITS{1'b0}}};
			err = xs - estimate;
			mag = err[63] ? -err : err;
			if (!loaded || (regs.bypass && !trk)) begin
				estimate = xs;
				loaded = 1'b1;
			end else if (mag >= ({48'd0, regs.deadband} << FRAC_BITS)) begin
				lim = {33'd0, (trk ? regs.snap_trk : regs.snap_slw)};
				if (lim != 0 && mag >= (lim << FRAC_BITS)) begin
					estimate = xs;
				end else begin
					alpha = trk ? regs.alpha_trk : regs.alpha_slw;
					if (alpha > ALPHA_ONE)
						alpha = ALPHA_ONE;
					prod = {18'd0, mag} * {65'd0, alpha} + 82'h8000;
					step = prod[79:16];
					estimate = err[63] ? estimate - step : estimate + step;
				end
			end
			// round half away from zero
			if (estimate[63]) begin
				r = (-estimate + 64'h8000) >> FRAC_BITS;
				r = -r;
			end else begin
				r = (estimate + 64'h8000) >> FRAC_BITS;
			end
			expected_positions.push_back(r[COUNT_WIDTH-1:0]);
		endfunction

		task report(string msg);
			if (mismatch_count < 40)
				$display("MISMATCH: %s", msg);
			mismatch_count++;
		endtask

		task check_output(logic [COUNT_WIDTH-1:0] got);
			logic [COUNT_WIDTH-1:0] want;
			if (expected_positions.size() == 0) begin
				report($sformatf("filtered_count %0d with nothing pending", $signed(got)));
			end else begin
				want = expected_positions.pop_front();
				if (got !== want)
					report($sformatf("filtered_count got %0d want %0d",
						$signed(got), $signed(want)));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [COUNT_WIDTH-1:0] s_tdata;   // [31:0] encoder_count
	logic                   s_tuser;   // [0] is_tracking
	logic                   m_tvalid;
	logic                   m_tready;
	logic [COUNT_WIDTH-1:0] m_tdata;   // [31:0] filtered_count

	ema_scoreboard          sb;
	bit                     quiet;
	bit                     hold_request;
	logic [COUNT_WIDTH-1:0] last_count;

	encoder_position_ema_filter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

	task send_sample(logic [COUNT_WIDTH-1:0] cnt, bit trk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cnt;
		s_tuser <= trk;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(cnt, trk);
		last_count = cnt;
	endtask

	// leaves cfg_valid high so back-to-back writes need one assignment per edge
	task put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task close_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task program_regs(logic [ALPHA_W-1:0] a_trk, logic [ALPHA_W-1:0] a_slw,
			logic [DB_W-1:0] db, logic [SNAP_W-1:0] sn_trk, logic [SNAP_W-1:0] sn_slw,
			bit byp);
		put_reg(IDX_ALPHA_TRK, CFG_DATA_W'(a_trk));
		put_reg(IDX_ALPHA_SLW, CFG_DATA_W'(a_slw));
		put_reg(IDX_DEADBAND, CFG_DATA_W'(db));
		put_reg(IDX_SNAP_TRK, CFG_DATA_W'(sn_trk));
		put_reg(IDX_SNAP_SLW, CFG_DATA_W'(sn_slw));
		put_reg(IDX_BYPASS, CFG_DATA_W'(byp));
	endtask

	task drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_positions.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [ALPHA_W-1:0] pick_alpha();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return ALPHA_ONE;
		2: return ALPHA_W'(1);
		3: return ALPHA_W'($urandom_range(65537, 131071));
		default: return ALPHA_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [SNAP_W-1:0] pick_snap();
		case ($urandom_range(0, 4))
		0: return '0;
		1: return '1;
		2: return SNAP_W'($urandom);
		default: return SNAP_W'($urandom_range(1, 5000));
		endcase
	endfunction

	function automatic logic [DB_W-1:0] pick_deadband();
		case ($urandom_range(0, 4))
		0: return '0;
		1: return '1;
		2: return DB_W'($urandom);
		default: return DB_W'($urandom_range(1, 30));
		endcase
	endfunction

	// mostly a walk around the last sample so deadband, snap and alpha all get hit
	function automatic logic [COUNT_WIDTH-1:0] next_count();
		int unsigned span;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			case ($urandom_range(0, 2))
			0: span = 4;
			1: span = 200;
			default: span = 20000;
			endcase
			return last_count + $urandom_range(0, 2 * span) - span;
		end else if (pick < 85) begin
			return $urandom;
		end else if (pick < 92) begin
			case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		return last_count + $urandom_range(0, 1 << 21) - (1 << 20);
	endfunction

	// output side: checks transfers and idles at random, with one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				hold_left = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		sb = new();
		quiet = 1'b0;
		hold_request = 1'b0;
		last_count = '0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first sample loads, alpha of one follows exactly
		send_sample(32'h8000_0000, TRACKING);
		send_sample(32'h7FFF_FFFF, SLEWING);
		send_sample(32'h0000_0000, TRACKING);
		send_sample(32'hFFFF_FFFF, TRACKING);
		drain();

		// half alpha while tracking, zero alpha while slewing, deadband and snap
		program_regs(ALPHA_W'(32768), '0, DB_W'(2), SNAP_W'(1000), '0, 1'b0);
		close_writes();
		send_sample(32'd0, TRACKING);
		send_sample(32'd1, TRACKING);
		send_sample(32'd3, TRACKING);
		send_sample(-32'sd2, TRACKING);
		send_sample(32'd5000, TRACKING);
		send_sample(-32'sd7, SLEWING);
		send_sample(-32'sd7, TRACKING);
		drain();

		// deadband larger than snap, bypass on slew, spare indexes written
		program_regs('1, ALPHA_W'(65537), '1, SNAP_W'(10), '1, 1'b1);
		put_reg(IDX_SPARE_LO, '1);
		put_reg(IDX_SPARE_HI, '1);
		close_writes();
		send_sample(32'd100, TRACKING);
		send_sample(32'h7FFF_FFFF, SLEWING);
		send_sample(32'h8000_0000, TRACKING);
		drain();

		// alpha above one clamps, alpha zero holds
		program_regs('1, '0, '0, '0, '0, 1'b0);
		close_writes();
		send_sample(32'd12345, TRACKING);
		send_sample(32'h8000_0000, TRACKING);
		send_sample(32'h7FFF_FFFF, SLEWING);
		send_sample(32'h7FFF_FFFF, TRACKING);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			program_regs(pick_alpha(), pick_alpha(), pick_deadband(), pick_snap(),
				pick_snap(), bit'($urandom_range(0, 1)));
			close_writes();
			quiet = (ph == PHASES - 1);
			if (ph == 0)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS)
				send_sample(next_count(), $urandom_range(0, 3) != 0);
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.expected_positions.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/epf_pkg.sv
rtl/epf_cfg_regs.sv
rtl/epf_update.sv
rtl/epf_round.sv
rtl/encoder_position_ema_filter_top.sv
rtl/epf_checker.sv
verif/encoder_position_ema_filter_top_tb.sv
